[design/mne_pkg.sv]
// Shared widths, norm kind codes and register indexes for the matrix norm engine.
// Has no dependencies; used by mne_isqrt and matrix_norm_engine.
`default_nettype none

package mne_pkg;

    localparam int ELEM_W = 16;
    localparam int MAG_W = 17;
    localparam int SQ_W = 2 * MAG_W;
    localparam int ACC_W = 22;
    localparam int TOTAL_W = 44;
    localparam int ROOT_W = TOTAL_W / 2;
    localparam int REM_W = ROOT_W + 2;
    localparam int SQRT_CNT_W = $clog2(ROOT_W);
    localparam int DIM_W = 7;
    localparam int KIND_W = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [KIND_W-1:0] KIND_MAX = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ONE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_INF = 2'd2;
    localparam logic [KIND_W-1:0] KIND_FROB = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_NORM_KIND = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = 2'd2;

    typedef logic [ACC_W-1:0] t_acc;
    typedef logic [TOTAL_W-1:0] t_total;

endpackage

`default_nettype wire

[design/mne_isqrt.sv]
// Iterative floor square root, one result bit per cycle, with a held result.
// Depends on mne_pkg for the radicand and root widths.
`default_nettype none

module mne_isqrt
    import mne_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [TOTAL_W-1:0] i_radicand,
    input  wire logic              i_take,
    output logic                   o_busy,
    output logic                   o_valid,
    output logic [ROOT_W-1:0]      o_root
);

    logic                  r_busy;
    logic                  r_valid;
    logic [SQRT_CNT_W-1:0] r_count;
    logic [TOTAL_W-1:0]    r_rad;
    logic [REM_W-1:0]      r_rem;
    logic [ROOT_W-1:0]     r_root;

    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic             fits;

    assign rem_sh = {r_rem[REM_W-3:0], r_rad[TOTAL_W-1 -: 2]};
    assign trial = {r_root, 2'b01};
    assign fits = rem_sh >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_valid <= 1'b0;
            r_count <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_count <= '0;
        end else if (r_busy) begin
            if (r_count == SQRT_CNT_W'(ROOT_W - 1)) begin
                r_busy <= 1'b0;
                r_valid <= 1'b1;
            end
            r_count <= r_count + 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad <= i_radicand;
            r_rem <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad <= {r_rad[TOTAL_W-3:0], 2'b00};
            r_rem <= fits ? (rem_sh - trial) : rem_sh;
            r_root <= {r_root[ROOT_W-2:0], fits};
        end
    end

    assign o_busy = r_busy || r_valid;
    assign o_valid = r_valid;
    assign o_root = r_root;

endmodule

`default_nettype wire

[design/matrix_norm_engine.sv]
// Streaming general-matrix norm: max, one, infinity or Frobenius norm of a Q8.8 matrix.
// Depends on mne_pkg and on mne_isqrt for the closing Frobenius root.
//
// Usage: configure norm kind, row count and column count through the write port
// (index 0, 1, 2) while the block is idle; any write restarts the matrix.
// Elements enter on the input channel in column-major order, one beat per
// element. The beat that completes rows x cols produces one result beat on the
// output channel; with zero rows or columns every element yields a zero result.
// An accepted element is registered with its row sum from the row-sum memory;
// when it is processed the new sum is written back; back-to-back hits on the
// same row are forwarded. One element per cycle is sustained while no result waits.
// Max, one and infinity results are loaded into the output register as the closing
// element is processed. A Frobenius result runs through the bit-serial root,
// during which elements keep flowing until another result would be emitted.
// When the receiver stalls, the output register holds the result and the input
// side keeps accepting until the next result has to wait.
// Reset restores kind max, one row, one column and clears the column-sum, maximum and square-sum accumulators.
`default_nettype none

module matrix_norm_engine
    import mne_pkg::*;
#(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [DIM_W-1:0]     i_cfg_data,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic signed [ELEM_W-1:0] i_element,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic [ACC_W-1:0]          o_norm_value
);

    localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int DIM_MAX = (1 << DIM_W) - 1;
    localparam int ROWS_CAP = (MAX_ROWS > DIM_MAX) ? DIM_MAX : MAX_ROWS;
    localparam int COLS_CAP = (MAX_COLS > DIM_MAX) ? DIM_MAX : MAX_COLS;

    logic [KIND_W-1:0] r_kind;
    logic [DIM_W-1:0]  r_row_count;
    logic [DIM_W-1:0]  r_col_count;
    logic [DIM_W-1:0]  r_row_pos;
    logic [DIM_W-1:0]  r_col_pos;

    logic              r_a_valid;
    logic              r_a_zero;
    logic [MAG_W-1:0]  r_a_mag;
    logic [SQ_W-1:0]   r_a_sq;
    logic [DIM_W-1:0]  r_a_row;
    logic              r_a_first_col;
    logic              r_a_last_row;
    logic              r_a_last_col;
    logic              r_a_fwd;

    t_acc              r_row_mem [MAX_ROWS];
    t_acc              r_mem_q;
    t_acc              r_last_wr;
    t_acc              r_col_sum;
    t_acc              r_max;
    t_total            r_sq_total;

    logic              r_out_valid;
    t_acc              r_out_data;

    logic [DIM_W-1:0]  rows_eff;
    logic [DIM_W-1:0]  cols_eff;
    logic [DIM_W-1:0]  row_cur;
    logic [DIM_W-1:0]  col_cur;
    logic              in_zero;
    logic              in_last_row;
    logic              in_last_col;
    logic              acc_in;
    logic [MAG_W-1:0]  in_mag;
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     wr_addr;

    t_acc              b_base;
    t_acc              rs_new;
    t_acc              cs_new;
    t_acc              max_new;
    t_total            tot_new;
    logic              b_last;
    logic              b_emit_direct;
    logic              b_emit_sqrt;
    logic              b_go;
    logic              b_upd;
    logic              out_free;

    logic              sq_busy;
    logic              sq_valid;
    logic              sq_take;
    logic [ROOT_W-1:0] sq_root;

    assign rows_eff = (r_row_count > DIM_W'(ROWS_CAP)) ? DIM_W'(ROWS_CAP) : r_row_count;
    assign cols_eff = (r_col_count > DIM_W'(COLS_CAP)) ? DIM_W'(COLS_CAP) : r_col_count;
    assign row_cur = (r_row_pos >= rows_eff) ? '0 : r_row_pos;
    assign col_cur = (r_col_pos >= cols_eff) ? '0 : r_col_pos;
    assign in_zero = (rows_eff == '0) || (cols_eff == '0);
    assign in_last_row = ({1'b0, row_cur} + 1'b1) == {1'b0, rows_eff};
    assign in_last_col = ({1'b0, col_cur} + 1'b1) == {1'b0, cols_eff};
    assign in_mag = i_element[ELEM_W-1] ? (MAG_W'(0) - {1'b1, i_element})
                                        : {1'b0, i_element};

    assign out_free = !r_out_valid || i_out_ready;
    assign b_last = r_a_last_row && r_a_last_col;
    assign b_emit_direct = r_a_valid && (r_a_zero || (b_last && r_kind != KIND_FROB));
    assign b_emit_sqrt = r_a_valid && !r_a_zero && b_last && r_kind == KIND_FROB;
    assign b_go = r_a_valid && !((b_emit_direct && (sq_busy || !out_free))
                                 || (b_emit_sqrt && sq_busy));
    assign b_upd = b_go && !r_a_zero;
    assign sq_take = sq_valid && out_free;

    assign o_in_ready = !r_a_valid || b_go;
    assign acc_in = i_in_valid && o_in_ready;
    assign rd_addr = AW'(row_cur);
    assign wr_addr = AW'(r_a_row);

    assign b_base = r_a_first_col ? '0 : (r_a_fwd ? r_last_wr : r_mem_q);
    assign rs_new = b_base + ACC_W'(r_a_mag);
    assign cs_new = r_col_sum + ACC_W'(r_a_mag);
    assign tot_new = r_sq_total + TOTAL_W'(r_a_sq);

    always_comb begin
        max_new = r_max;
        case (r_kind)
            KIND_MAX: begin
                if (ACC_W'(r_a_mag) > r_max) max_new = ACC_W'(r_a_mag);
            end
            KIND_ONE: begin
                if (r_a_last_row && cs_new > r_max) max_new = cs_new;
            end
            KIND_INF: begin
                if (r_a_last_col && rs_new > r_max) max_new = rs_new;
            end
            default: begin
                max_new = r_max;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind <= KIND_MAX;
            r_row_count <= DIM_W'(1);
            r_col_count <= DIM_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_NORM_KIND: r_kind <= i_cfg_data[KIND_W-1:0];
                CFG_ROW_COUNT: r_row_count <= i_cfg_data;
                CFG_COL_COUNT: r_col_count <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_row_pos <= '0;
            r_col_pos <= '0;
        end else if (acc_in && !in_zero) begin
            if (in_last_row) begin
                r_row_pos <= '0;
                r_col_pos <= in_last_col ? '0 : col_cur + 1'b1;
            end else begin
                r_row_pos <= row_cur + 1'b1;
                r_col_pos <= col_cur;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (acc_in) begin
            r_a_valid <= 1'b1;
        end else if (b_go) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_in) begin
            r_a_zero <= in_zero;
            r_a_mag <= in_mag;
            r_a_sq <= SQ_W'(in_mag) * SQ_W'(in_mag);
            r_a_row <= row_cur;
            r_a_first_col <= col_cur == '0;
            r_a_last_row <= in_last_row;
            r_a_last_col <= in_last_col;
            r_a_fwd <= b_upd && (wr_addr == rd_addr);
            r_mem_q <= r_row_mem[rd_addr];
        end
        if (b_upd) begin
            r_row_mem[wr_addr] <= rs_new;
            r_last_wr <= rs_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_col_sum <= '0;
            r_max <= '0;
            r_sq_total <= '0;
        end else if (b_upd) begin
            if (b_last) begin
                r_col_sum <= '0;
                r_max <= '0;
                r_sq_total <= '0;
            end else begin
                r_col_sum <= r_a_last_row ? '0 : cs_new;
                r_max <= max_new;
                r_sq_total <= tot_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (sq_take || (b_go && b_emit_direct)) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (sq_take) begin
            r_out_data <= sq_root;
        end else if (b_go && b_emit_direct) begin
            r_out_data <= r_a_zero ? '0 : max_new;
        end
    end

    mne_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (b_go && b_emit_sqrt),
        .i_radicand (tot_new),
        .i_take     (sq_take),
        .o_busy     (sq_busy),
        .o_valid    (sq_valid),
        .o_root     (sq_root)
    );

    assign o_out_valid = r_out_valid;
    assign o_norm_value = r_out_data;

    a_single_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(sq_take && b_go && b_emit_direct))
        else $error("root result and direct result loaded together");

    a_row_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && !r_a_zero) |-> (r_a_row < rows_eff))
        else $error("row position outside the configured rows");

    a_column_sum_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && !r_a_zero && r_a_row == '0) |-> (r_col_sum == '0))
        else $error("column sum not cleared at the start of a column");

    a_forward_same_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc_in && b_upd && wr_addr == rd_addr && !in_zero) |-> (rows_eff == DIM_W'(1)))
        else $error("same-row hit on consecutive elements with more than one row");

endmodule

`default_nettype wire
